@@ rtl/core/qsu_pkg.sv @@
// ----------------------------------------------------------------------------
// qsu_pkg: shared types and constants of the quoted string unescaper
// Holds the classified byte record that travels from the front end to the
// back end, the result kind codes and the byte classifier.
// ----------------------------------------------------------------------------
package qsu_pkg;

   localparam int unsigned QDepth = 4;
   localparam int unsigned QPtrW  = $clog2(QDepth);
   localparam int unsigned QCntW  = $clog2(QDepth + 1);

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_END   = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   // What a byte means when it follows a backslash.
   typedef enum logic [1:0] {
      ESC_EMIT = 2'd0,
      ESC_NONE = 2'd1,
      ESC_HEX  = 2'd2,
      ESC_BAD  = 2'd3
   } esc_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       first;
      logic       last;
      logic       is_bslash;
      esc_type    esc;
      logic [7:0] esc_byte;
      logic       digit_ok;
      logic [5:0] digit;
   } item_type;

   function automatic item_type classify(input logic [7:0] ch, input logic first,
                                         input logic last);
      item_type   it;
      logic [7:0] diff;
      it           = '0;
      it.ch        = ch;
      it.first     = first;
      it.last      = last;
      it.is_bslash = (ch == 8'h5C);
      it.esc       = ESC_EMIT;
      it.esc_byte  = 8'h00;
      unique case (ch)
         8'h74:   it.esc_byte = 8'h09;   // t
         8'h72:   it.esc_byte = 8'h0D;   // r
         8'h6E:   it.esc_byte = 8'h0A;   // n
         8'h5C:   it.esc_byte = 8'h5C;   // backslash
         8'h22:   it.esc_byte = 8'h22;   // double quote
         8'h27:   it.esc_byte = 8'h27;   // single quote
         8'h64:   it.esc_byte = 8'h04;   // d
         8'h2E:   it.esc      = ESC_NONE;
         8'h78:   it.esc      = ESC_HEX;
         default: it.esc      = ESC_BAD;
      endcase
      it.digit_ok = 1'b0;
      diff        = 8'h00;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         it.digit_ok = 1'b1;
         diff        = ch - 8'h30;
      end else if (ch >= 8'h41 && ch <= 8'h5A) begin
         it.digit_ok = 1'b1;
         diff        = ch - 8'h41 + 8'd10;
      end
      it.digit = diff[5:0];
      return it;
   endfunction

endpackage

@@ rtl/core/quoted_string_unescaper.sv @@
// ----------------------------------------------------------------------------
// quoted_string_unescaper: backslash escape decoder for quoted strings
// Removes the enclosing quotes of a string and decodes backslash escapes.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel takes one source byte per transaction in req_tdata, with
//   req_tuser[0] set on the opening quote and req_tlast set on the closing
//   quote. The rsp channel gives zero or one result per source byte: a
//   decoded byte in rsp_tdata with kind 0 in rsp_tuser, an end of string
//   (kind 1) or an escape error (kind 2); end and error results carry 0.
//   After an error the rest of that string gives no results.
//   With an empty queue, an accepted byte is registered in the queue and its
//   result then in the output register, from which rsp takes it.
//   Throughput is one byte per cycle unless rsp stalls: the back end decodes
//   one queued byte per cycle, limited by its single parse-mode register.
//   A four-entry queue sits between classifier and decoder; when rsp_tready
//   is low the result is held, the decoder stops and the queue fills, and
//   req_tready drops only once the queue is full.
//   Reset (synchronous, active high) empties the queue and output register
//   and returns the decoder to normal text mode.
// ----------------------------------------------------------------------------
module quoted_string_unescaper (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_in
   input  logic [0:0] req_tuser,   // [0] first_of_string
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser    // [1:0] kind
);

   logic              q_push;
   logic              q_pop;
   logic              q_full;
   logic              q_not_empty;
   qsu_pkg::item_type q_in_item;
   qsu_pkg::item_type q_head;

   qsu_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (q_in_item)
   );

   qsu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   qsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_not_empty),
      .q_item     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ rtl/core/qsu_front.sv @@
// ----------------------------------------------------------------------------
// qsu_front: input stage
// Accepts source bytes and classifies each one before it enters the queue.
// ----------------------------------------------------------------------------
module qsu_front (
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,
   input  logic [0:0]        req_tuser,
   input  logic              req_tlast,
   input  logic              q_full,
   output logic              q_push,
   output qsu_pkg::item_type q_item
);

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;
   assign q_item     = qsu_pkg::classify(req_tdata, req_tuser[0], req_tlast);

endmodule

@@ rtl/core/qsu_queue.sv @@
// ----------------------------------------------------------------------------
// qsu_queue: classified byte queue
// A short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module qsu_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  qsu_pkg::item_type push_item,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output qsu_pkg::item_type head
);

   qsu_pkg::item_type                 mem_ff [qsu_pkg::QDepth];
   logic [qsu_pkg::QPtrW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [qsu_pkg::QPtrW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [qsu_pkg::QCntW-1:0]         count_ff, count_in;

   assign full      = (count_ff == qsu_pkg::QCntW'(qsu_pkg::QDepth));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= qsu_pkg::QCntW'(qsu_pkg::QDepth))
      else $error("queue count exceeds depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("push into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from an empty queue");

endmodule

@@ rtl/core/qsu_back.sv @@
// ----------------------------------------------------------------------------
// qsu_back: escape decoder
// Tracks the parse mode over a string and produces decoded bytes, end and
// error results into an output register.
// ----------------------------------------------------------------------------
module qsu_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  qsu_pkg::item_type q_item,
   output logic              q_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic [1:0]        rsp_tuser
);

   typedef enum logic [2:0] {
      MODE_NORMAL   = 3'd0,
      MODE_ESCAPE   = 3'd1,
      MODE_HEX_HIGH = 3'd2,
      MODE_HEX_LOW  = 3'd3,
      MODE_SKIP     = 3'd4
   } mode_type;

   mode_type          mode_ff, mode_in;
   logic [3:0]        high_ff, high_in;
   logic              valid_ff, valid_in;
   logic [7:0]        data_ff, data_in;
   qsu_pkg::kind_type kind_ff, kind_in;

   logic              emit;
   logic [7:0]        emit_byte;
   qsu_pkg::kind_type emit_kind;

   assign q_pop = q_valid && (!valid_ff || rsp_tready);

   always_comb begin
      mode_in   = mode_ff;
      high_in   = high_ff;
      emit      = 1'b0;
      emit_byte = 8'h00;
      emit_kind = qsu_pkg::KIND_BYTE;
      if (q_item.first) begin
         mode_in = MODE_NORMAL;
         if (q_item.last) begin
            emit      = 1'b1;
            emit_kind = qsu_pkg::KIND_END;
         end
      end else if (q_item.last) begin
         mode_in = MODE_NORMAL;
         if (mode_ff != MODE_SKIP) begin
            emit      = 1'b1;
            emit_kind = (mode_ff == MODE_NORMAL) ? qsu_pkg::KIND_END : qsu_pkg::KIND_ERROR;
         end
      end else begin
         unique case (mode_ff)
            MODE_SKIP: begin
            end
            MODE_ESCAPE: begin
               mode_in = MODE_NORMAL;
               unique case (q_item.esc)
                  qsu_pkg::ESC_EMIT: begin
                     emit      = 1'b1;
                     emit_byte = q_item.esc_byte;
                  end
                  qsu_pkg::ESC_NONE: begin
                  end
                  qsu_pkg::ESC_HEX: begin
                     mode_in = MODE_HEX_HIGH;
                  end
                  qsu_pkg::ESC_BAD: begin
                     mode_in   = MODE_SKIP;
                     emit      = 1'b1;
                     emit_kind = qsu_pkg::KIND_ERROR;
                  end
               endcase
            end
            MODE_HEX_HIGH: begin
               if (q_item.digit_ok) begin
                  mode_in = MODE_HEX_LOW;
                  high_in = q_item.digit[3:0];
               end else begin
                  mode_in   = MODE_SKIP;
                  emit      = 1'b1;
                  emit_kind = qsu_pkg::KIND_ERROR;
               end
            end
            MODE_HEX_LOW: begin
               emit = 1'b1;
               if (q_item.digit_ok) begin
                  mode_in   = MODE_NORMAL;
                  // A digit above 15 overlaps the high nibble, as the OR implies.
                  emit_byte = {high_ff, 4'h0} | {2'b00, q_item.digit};
               end else begin
                  mode_in   = MODE_SKIP;
                  emit_kind = qsu_pkg::KIND_ERROR;
               end
            end
            default: begin
               if (q_item.is_bslash) begin
                  mode_in = MODE_ESCAPE;
               end else begin
                  emit      = 1'b1;
                  emit_byte = q_item.ch;
               end
            end
         endcase
      end
   end

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      kind_in  = kind_ff;
      if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (q_pop && emit) begin
         valid_in = 1'b1;
         data_in  = emit_byte;
         kind_in  = emit_kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_NORMAL;
         high_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            mode_ff <= mode_in;
            high_ff <= high_in;
         end
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
      kind_ff <= kind_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = kind_ff;

   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind_ff != qsu_pkg::KIND_BYTE) |-> (data_ff == 8'h00))
      else $error("end or error result carries a nonzero byte");
   a_pop_room: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (!valid_ff || rsp_tready))
      else $error("item taken while the output register is blocked");
   a_hex_order: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_HEX_LOW && !$past(reset)) |->
         ($past(mode_ff) == MODE_HEX_HIGH || $past(mode_ff) == MODE_HEX_LOW))
      else $error("second digit mode entered out of order");
   a_skip_quiet: assert property (@(posedge clock) disable iff (reset)
      (q_pop && mode_ff == MODE_SKIP && !q_item.first) |-> !emit)
      else $error("result produced while skipping after an error");

endmodule

@@ verif/quoted_string_unescaper_tb.sv @@
// ----------------------------------------------------------------------------
// quoted_string_unescaper_tb: self-checking bench for the string unescaper
// Feeds quoted strings byte by byte, predicts every decoded byte, end and
// error result in a behavioral decoder, and checks each rsp transaction in
// order while both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module quoted_string_unescaper_tb;

   localparam int RxHoldLen     = 300;
   localparam int WatchdogLimit = 2000;
   localparam int TailCycles    = 8;

   localparam logic [7:0] ChBslash = 8'h5C;
   localparam logic [7:0] ChQuote  = 8'h22;
   localparam logic [7:0] ChApos   = 8'h27;
   localparam logic [7:0] ChZero   = 8'h30;
   localparam logic [7:0] ChNine   = 8'h39;
   localparam logic [7:0] ChUpperA = 8'h41;
   localparam logic [7:0] ChUpperZ = 8'h5A;
   localparam logic [7:0] EscTab   = 8'h74;
   localparam logic [7:0] EscCr    = 8'h72;
   localparam logic [7:0] EscLf    = 8'h6E;
   localparam logic [7:0] EscFour  = 8'h64;
   localparam logic [7:0] EscDot   = 8'h2E;
   localparam logic [7:0] EscHex   = 8'h78;

   typedef enum logic [2:0] {
      PM_TEXT,
      PM_ESCAPE,
      PM_HEX_HIGH,
      PM_HEX_LOW,
      PM_SKIP
   } parse_mode_type;

   typedef struct packed {
      logic [7:0]        data;
      qsu_pkg::kind_type kind;
   } decoded_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] char_in
   logic [0:0] req_tuser  = 1'b0;    // [0] first_of_string
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [7:0] out_byte
   logic [1:0] rsp_tuser;            // [1:0] kind

   decoded_type    expected_results[$];
   parse_mode_type pm_mode = PM_TEXT;
   logic [3:0]     pm_high = 4'h0;

   int tx_idle_pct   = 0;
   int rx_idle_pct   = 0;
   bit rx_hold_armed = 1'b0;
   int rx_hold_cnt   = 0;
   int items_sent    = 0;
   int results_seen  = 0;
   int mismatches    = 0;
   int stall_cycles  = 0;

   // Escapes that produce at most one byte and need no digits.
   logic [7:0] simple_escs [0:7] = '{EscTab, EscCr, EscLf, ChBslash,
                                     ChQuote, ChApos, EscFour, EscDot};

   quoted_string_unescaper u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int digit_of(input logic [7:0] c);
      if (c >= ChZero && c <= ChNine) return int'(c - ChZero);
      if (c >= ChUpperA && c <= ChUpperZ) return int'(c - ChUpperA) + 10;
      return -1;
   endfunction

   function automatic logic [7:0] digit_char(input int d);
      if (d < 10) return ChZero + 8'(d);
      return ChUpperA + 8'(d - 10);
   endfunction

   function automatic void expect_result(input logic [7:0] data,
                                         input qsu_pkg::kind_type kind);
      decoded_type r;
      r.data = data;
      r.kind = kind;
      expected_results.push_back(r);
   endfunction

   // Behavioral decoder, advanced once per accepted req transaction.
   function automatic void predict_decode(input logic [7:0] ch, input logic first,
                                          input logic last);
      parse_mode_type cur;
      int             d;
      cur = pm_mode;
      d   = digit_of(ch);
      if (first) begin
         pm_mode = PM_TEXT;
         if (last) expect_result(8'h00, qsu_pkg::KIND_END);
      end else if (last) begin
         pm_mode = PM_TEXT;
         if (cur == PM_ESCAPE || cur == PM_HEX_HIGH || cur == PM_HEX_LOW)
            expect_result(8'h00, qsu_pkg::KIND_ERROR);
         else if (cur != PM_SKIP)
            expect_result(8'h00, qsu_pkg::KIND_END);
      end else begin
         case (cur)
            PM_SKIP: begin
            end
            PM_ESCAPE: begin
               pm_mode = PM_TEXT;
               case (ch)
                  EscTab:   expect_result(8'h09, qsu_pkg::KIND_BYTE);
                  EscCr:    expect_result(8'h0D, qsu_pkg::KIND_BYTE);
                  EscLf:    expect_result(8'h0A, qsu_pkg::KIND_BYTE);
                  ChBslash: expect_result(ChBslash, qsu_pkg::KIND_BYTE);
                  ChQuote:  expect_result(ChQuote, qsu_pkg::KIND_BYTE);
                  ChApos:   expect_result(ChApos, qsu_pkg::KIND_BYTE);
                  EscFour:  expect_result(8'h04, qsu_pkg::KIND_BYTE);
                  EscDot: begin
                  end
                  EscHex:   pm_mode = PM_HEX_HIGH;
                  default: begin
                     pm_mode = PM_SKIP;
                     expect_result(8'h00, qsu_pkg::KIND_ERROR);
                  end
               endcase
            end
            PM_HEX_HIGH: begin
               if (d < 0) begin
                  pm_mode = PM_SKIP;
                  expect_result(8'h00, qsu_pkg::KIND_ERROR);
               end else begin
                  pm_high = d[3:0];
                  pm_mode = PM_HEX_LOW;
               end
            end
            PM_HEX_LOW: begin
               if (d < 0) begin
                  pm_mode = PM_SKIP;
                  expect_result(8'h00, qsu_pkg::KIND_ERROR);
               end else begin
                  // Digits above 15 spill into the high nibble, as in the OR.
                  pm_mode = PM_TEXT;
                  expect_result({pm_high, 4'h0} | 8'(d), qsu_pkg::KIND_BYTE);
               end
            end
            default: begin
               if (ch == ChBslash) pm_mode = PM_ESCAPE;
               else expect_result(ch, qsu_pkg::KIND_BYTE);
            end
         endcase
      end
   endfunction

   function automatic void check_result(input logic [7:0] data, input logic [1:0] kind);
      decoded_type exp;
      results_seen++;
      if (expected_results.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("result %0d: unexpected transaction data=%02h kind=%0d",
                     results_seen, data, kind);
      end else begin
         exp = expected_results.pop_front();
         if (data !== exp.data || kind !== exp.kind) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result %0d: expected data=%02h kind=%0d, got data=%02h kind=%0d",
                        results_seen, exp.data, exp.kind, data, kind);
         end
      end
   endfunction

   // Receiver: random ready, or a long hold-off once it is armed.
   always @(posedge clock) begin
      if (rx_hold_armed && rx_hold_cnt < RxHoldLen) begin
         rsp_tready  <= 1'b0;
         rx_hold_cnt <= rx_hold_cnt + 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
      if (!reset && rsp_tvalid && rsp_tready) check_result(rsp_tdata, rsp_tuser);
   end

   // Watchdog: ends the run when no transaction moves on either side.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles + 1 >= WatchdogLimit) begin
         $display("watchdog: no transaction for %0d cycles", WatchdogLimit);
         $display("quoted_string_unescaper: mismatch");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_item(input logic [7:0] ch, input logic first, input logic last);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tuser  <= first;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_decode(ch, first, last);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);
   endtask

   // A mostly well-formed string with random content.
   task automatic send_random_string();
      int         tokens;
      int         r;
      logic [7:0] c;
      tokens = $urandom_range(10);
      send_item(8'($urandom_range(255)), 1'b1, 1'b0);
      repeat (tokens) begin
         r = $urandom_range(99);
         if (r < 45) begin
            c = 8'($urandom_range(255));
            if (c == ChBslash) send_item(ChBslash, 1'b0, 1'b0);
            send_item(c, 1'b0, 1'b0);
         end else if (r < 75) begin
            send_item(ChBslash, 1'b0, 1'b0);
            send_item(simple_escs[$urandom_range(7)], 1'b0, 1'b0);
         end else if (r < 90) begin
            send_item(ChBslash, 1'b0, 1'b0);
            send_item(EscHex, 1'b0, 1'b0);
            send_item(digit_char($urandom_range(35)), 1'b0, 1'b0);
            send_item(digit_char($urandom_range(35)), 1'b0, 1'b0);
         end else if (r < 95) begin
            c = 8'($urandom_range(255));
            while (c inside {EscTab, EscCr, EscLf, ChBslash, ChQuote, ChApos,
                             EscFour, EscDot, EscHex})
               c = 8'($urandom_range(255));
            send_item(ChBslash, 1'b0, 1'b0);
            send_item(c, 1'b0, 1'b0);
         end else begin
            c = 8'($urandom_range(255));
            while (digit_of(c) >= 0) c = 8'($urandom_range(255));
            send_item(ChBslash, 1'b0, 1'b0);
            send_item(EscHex, 1'b0, 1'b0);
            if ($urandom_range(1)) send_item(digit_char($urandom_range(35)), 1'b0, 1'b0);
            send_item(c, 1'b0, 1'b0);
         end
      end
      // Now and then the string closes in the middle of an escape.
      r = $urandom_range(99);
      if (r < 8) begin
         send_item(ChBslash, 1'b0, 1'b0);
         if (r >= 3) send_item(EscHex, 1'b0, 1'b0);
         if (r >= 6) send_item(digit_char($urandom_range(35)), 1'b0, 1'b0);
      end
      send_item(8'($urandom_range(255)), 1'b0, 1'b1);
   endtask

   task automatic test_directed();
      tx_idle_pct = 7;
      rx_idle_pct = 64;
      // Empty string: opening and closing on the same byte.
      send_item(ChQuote, 1'b1, 1'b1);
      send_item(ChQuote, 1'b1, 1'b0);
      foreach (simple_escs[i]) begin
         send_item(ChBslash, 1'b0, 1'b0);
         send_item(simple_escs[i], 1'b0, 1'b0);
      end
      // Hex escape whose first digit is above 15.
      send_item(ChBslash, 1'b0, 1'b0);
      send_item(EscHex, 1'b0, 1'b0);
      send_item(ChUpperZ, 1'b0, 1'b0);
      send_item(ChZero, 1'b0, 1'b0);
      send_item(8'hFF, 1'b0, 1'b0);
      // A new string opens while the old one is inside an escape.
      send_item(ChBslash, 1'b0, 1'b0);
      send_item(ChQuote, 1'b1, 1'b0);
      // Bad hex digit, then bytes ignored up to a silent close.
      send_item(ChBslash, 1'b0, 1'b0);
      send_item(EscHex, 1'b0, 1'b0);
      send_item(8'h3A, 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(ChQuote, 1'b0, 1'b1);
      // Outside any string, then a close right after a backslash.
      send_item(8'h00, 1'b0, 1'b0);
      send_item(ChBslash, 1'b0, 1'b0);
      send_item(ChQuote, 1'b0, 1'b1);
   endtask

   task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_items);
      int target;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      target      = items_sent + n_items;
      while (items_sent < target) begin
         if ($urandom_range(99) < 10)
            send_item(8'($urandom_range(255)), ($urandom_range(99) < 15),
                      ($urandom_range(99) < 15));
         else
            send_random_string();
      end
   endtask

   // The sender stops until every pending result has come back.
   task automatic test_drain_pause();
      repeat (3) begin
         send_random_string();
         wait_drained();
      end
   endtask

   // The receiver holds off long enough for the block to stall req.
   task automatic test_backpressure();
      tx_idle_pct   = 0;
      rx_idle_pct   = 0;
      rx_hold_armed = 1'b1;
      send_item(ChQuote, 1'b1, 1'b0);
      repeat (40) send_item(8'($urandom_range(8'h20, 8'h5B)), 1'b0, 1'b0);
      send_item(ChQuote, 1'b0, 1'b1);
      while (rx_hold_cnt < RxHoldLen) @(posedge clock);
      wait_drained();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_traffic(7, 64, 130);
      test_drain_pause();
      test_random_traffic(64, 7, 130);
      test_backpressure();
      test_random_traffic(0, 0, 120);
      wait_drained();
      if (expected_results.size() != 0)
         $display("%0d expected results never arrived", expected_results.size());
      if (mismatches == 0 && expected_results.size() == 0)
         $display("quoted_string_unescaper: match");
      else
         $display("quoted_string_unescaper: mismatch");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/qsu_pkg.sv
rtl/core/qsu_front.sv
rtl/core/qsu_queue.sv
rtl/core/qsu_back.sv
rtl/core/quoted_string_unescaper.sv
verif/quoted_string_unescaper_tb.sv
